// File: rtl/sdfr_pkg.sv
// Shared types and constants for the serial delimiter frame receiver.
// No dependencies; used by sdfr_step and the top level.
package sdfr_pkg;

   localparam int FRAME_LIMIT = 512;
   localparam int CNT_W       = $clog2(FRAME_LIMIT + 1);
   localparam int MAXLEN_W    = 10;
   localparam int LIM_W       = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 10;

   localparam logic [7:0]          DELIM_RESET  = 8'hC0;
   localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(300);

   localparam logic [CSR_IDX_W-1:0] REG_DELIM  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAXLEN = CSR_IDX_W'(1);

   typedef struct packed {
      logic [7:0]       win;
      logic [3:0]       bit_cnt;
      logic             in_frame;
      logic [CNT_W-1:0] byte_cnt;
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       frame_last;
      logic       overflow;
   } result_type;

endpackage

// File: rtl/sdfr_req_if.sv
// Input channel: one sampled line bit per word.
// Depends on nothing.
interface sdfr_req_if;
   logic valid;
   logic ready;
   logic serial_bit;

   modport source (output valid, output serial_bit, input ready);
   modport sink   (input valid, input serial_bit, output ready);
endinterface

// File: rtl/sdfr_rsp_if.sv
// Result channel: one received byte with its frame flags per word.
// Depends on nothing.
interface sdfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   logic       frame_last;
   logic       overflow;

   modport source (output valid, output data_byte, output frame_start,
                   output frame_last, output overflow, input ready);
   modport sink   (input valid, input data_byte, input frame_start,
                   input frame_last, input overflow, output ready);
endinterface

// File: rtl/sdfr_step.sv
// Next-state and result logic for one line bit (hunt window and byte assembly).
// Depends on sdfr_pkg.
module sdfr_step (
   input  sdfr_pkg::state_type           cur,
   input  logic                          serial_bit,
   input  logic [7:0]                    delimiter,
   input  logic [sdfr_pkg::MAXLEN_W-1:0] max_len,
   output sdfr_pkg::state_type           nxt,
   output logic                          emit,
   output sdfr_pkg::result_type          res
);

   logic [sdfr_pkg::LIM_W-1:0] limit;
   logic [sdfr_pkg::LIM_W-1:0] raw_len;
   logic [7:0]                 win_set;
   logic [7:0]                 win_hunt;
   logic [3:0]                 cnt_inc;
   logic [sdfr_pkg::CNT_W-1:0] bytes_inc;
   logic                       hunt_full;

   // Clamp the length register to 2..FRAME_LIMIT.
   always_comb begin
      raw_len = sdfr_pkg::LIM_W'(max_len);
      if (raw_len < sdfr_pkg::LIM_W'(2)) begin
         limit = sdfr_pkg::LIM_W'(2);
      end else if (raw_len > sdfr_pkg::LIM_W'(sdfr_pkg::FRAME_LIMIT)) begin
         limit = sdfr_pkg::LIM_W'(sdfr_pkg::FRAME_LIMIT);
      end else begin
         limit = raw_len;
      end
   end

   assign win_set   = cur.win | (8'(serial_bit) << cur.bit_cnt[2:0]);
   assign cnt_inc   = cur.bit_cnt + 4'd1;
   assign hunt_full = (cur.bit_cnt >= 4'd8);
   assign win_hunt  = hunt_full ? {serial_bit, cur.win[7:1]} : win_set;
   assign bytes_inc = cur.byte_cnt + sdfr_pkg::CNT_W'(1);

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '{data_byte: win_set, frame_start: 1'b0, frame_last: 1'b0,
               overflow: 1'b0};
      if (!cur.in_frame) begin
         nxt.win     = win_hunt;
         nxt.bit_cnt = hunt_full ? 4'd8 : cnt_inc;
         res.data_byte = win_hunt;
         if ((hunt_full || cnt_inc == 4'd8) && win_hunt == delimiter) begin
            emit            = 1'b1;
            res.frame_start = 1'b1;
            nxt.in_frame    = 1'b1;
            nxt.win         = '0;
            nxt.bit_cnt     = '0;
            nxt.byte_cnt    = sdfr_pkg::CNT_W'(1);
         end
      end else begin
         nxt.win     = win_set;
         nxt.bit_cnt = cnt_inc;
         if (cnt_inc == 4'd8) begin
            emit         = 1'b1;
            nxt.win      = '0;
            nxt.bit_cnt  = '0;
            nxt.byte_cnt = bytes_inc;
            if (win_set == delimiter) begin
               res.frame_last = 1'b1;
               nxt            = '0;
            end else if (sdfr_pkg::LIM_W'(bytes_inc) >= limit) begin
               // cut the frame at the length limit
               res.frame_last = 1'b1;
               res.overflow   = 1'b1;
               nxt            = '0;
            end
         end
      end
   end

endmodule

// File: rtl/serial_delimiter_frame_receiver_top.sv
// Top level of the serial delimiter frame receiver: input register, state,
// result register and configuration registers. Depends on sdfr_pkg,
// sdfr_req_if, sdfr_rsp_if and sdfr_step.
//
//   channel    direction  word
//   req_chan   in         serial_bit (1 line sample)
//   rsp_chan   out        data_byte, frame_start, frame_last, overflow
//   csr_*      in         write enable, index, data (no read-back)
//
// One line bit per cycle while rsp_chan does not stall; an accepted bit goes
// through the input register, then the step logic into the result register.
// A bit that completes no byte leaves the result register untouched.
// A stalled result holds the step; req_chan.ready drops only when the input
// register is full and the result register cannot take a new byte.
// Synchronous reset returns to hunting with window and counters cleared.
module serial_delimiter_frame_receiver_top (
   input  logic                             clock,
   input  logic                             reset,
   sdfr_req_if.sink                         req_chan,
   sdfr_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [sdfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sdfr_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_bit_ff;
   sdfr_pkg::state_type           state_ff, state_in;
   logic                          out_valid_ff, out_valid_in;
   sdfr_pkg::result_type          out_ff;
   logic [7:0]                    delim_ff;
   logic [sdfr_pkg::MAXLEN_W-1:0] maxlen_ff;

   sdfr_pkg::state_type  step_nxt;
   sdfr_pkg::result_type step_res;
   logic                 step_emit;
   logic                 out_free;
   logic                 advance;

   sdfr_step u_step (
      .cur        (state_ff),
      .serial_bit (in_bit_ff),
      .delimiter  (delim_ff),
      .max_len    (maxlen_ff),
      .nxt        (step_nxt),
      .emit       (step_emit),
      .res        (step_res)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !out_free);
   assign state_in     = advance ? step_nxt : state_ff;
   assign out_valid_in = advance ? step_emit : (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: capture only when the stage moves
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_bit_ff <= req_chan.serial_bit;
      end
      if (advance && step_emit) begin
         out_ff <= step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff  <= sdfr_pkg::DELIM_RESET;
         maxlen_ff <= sdfr_pkg::MAXLEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sdfr_pkg::REG_DELIM:  delim_ff  <= csr_write_data[7:0];
            sdfr_pkg::REG_MAXLEN: maxlen_ff <= csr_write_data[sdfr_pkg::MAXLEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.data_byte   = out_ff.data_byte;
   assign rsp_chan.frame_start = out_ff.frame_start;
   assign rsp_chan.frame_last  = out_ff.frame_last;
   assign rsp_chan.overflow    = out_ff.overflow;

   a_start_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.frame_start && out_ff.frame_last))
      else $error("byte flagged as both frame start and frame last");

   a_overflow_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.overflow) |-> out_ff.frame_last)
      else $error("cut byte not flagged as frame last");

   a_frame_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff.in_frame |-> (state_ff.bit_cnt < 4'd8 &&
                             state_ff.byte_cnt != '0))
      else $error("frame counters out of range");

   a_hunt_counts: assert property (@(posedge clock) disable iff (reset)
      !state_ff.in_frame |-> (state_ff.bit_cnt <= 4'd8 && state_ff.byte_cnt == '0))
      else $error("hunt counters out of range");

   a_start_enters_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit && step_res.frame_start) |=> state_ff.in_frame)
      else $error("frame start did not enter frame mode");

endmodule
